@@ design/id_match_message_fifo_unit_macros.svh @@
// assertion macros for the id match message fifo
`ifndef ID_MATCH_MESSAGE_FIFO_UNIT_MACROS_SVH
`define ID_MATCH_MESSAGE_FIFO_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// plain property, checked while out of reset
`define IMM_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication, consequent in the same cycle
`define IMM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error("implication failed");

`else

`define IMM_ASSERT(lbl, clk, rstn, prop, msg)
`define IMM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ design/imm_pkg.sv @@
`timescale 1ns / 1ps

package imm_pkg;

	localparam int ENTRIES_DEF       = 16;
	localparam int PAYLOAD_BYTES_DEF = 8;

	localparam int ID_W   = 29;
	localparam int LEN_W  = 4;
	localparam int DATA_W = 64;
	localparam int FILL_W = 5;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_TAKE = 2'd1,
		OP_DROP = 2'd2
	} imm_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DROPPED   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} imm_status_t;

	typedef struct packed {
		imm_op_t             operation;
		logic [ID_W-1:0]     msg_id;
		logic [LEN_W-1:0]    length_code;
		logic [DATA_W-1:0]   payload;
	} imm_req_t;

	typedef struct packed {
		imm_status_t         status;
		logic [DATA_W-1:0]   found_payload;
		logic [LEN_W-1:0]    found_length;
		logic [FILL_W-1:0]   fill_level;
	} imm_rsp_t;

	// sequencer to datapath
	typedef struct packed {
		logic        busy;
		logic        done;
		imm_status_t status;
		logic        hit;
		logic        wr_en;
		logic        wr_new;
	} imm_ctl_t;

endpackage

@@ design/id_match_message_fifo_unit.sv @@
`timescale 1ns / 1ps

// Message store with identifier match. A request is taken at a rising edge with start high
// and busy low; busy then stays high until the result. Every request returns exactly one
// result, shown for a single cycle with done high; the receiver cannot stall it, so it must
// sample result whenever done is high. Add, drop, unused operation codes and a take on an
// empty store finish straight from the dispatch state. Any other take goes on to a search:
// entries live in one RAM with a single read port, so the search scans one entry per cycle
// from the oldest and the gap after a hit is closed by moving one entry per cycle. A new
// request may be taken in the cycle that done is high. Entries are held oldest first in a
// ring; an add on a full store overwrites the oldest slot and reports the drop.
module id_match_message_fifo_unit #(
	parameter int ENTRIES       = imm_pkg::ENTRIES_DEF,
	parameter int PAYLOAD_BYTES = imm_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  imm_pkg::imm_req_t request,
	output logic             done,
	output imm_pkg::imm_rsp_t result
);

	import imm_pkg::*;

	localparam int AW    = $clog2(ENTRIES);
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int PAY_W = 8 * PAYLOAD_BYTES;
	localparam int ENT_W = ID_W + LEN_W + PAY_W;

	// captured request
	imm_req_t          req_q;
	logic              accept;

	// found fields, cleared per request and loaded on a hit
	logic [PAY_W-1:0]  found_payload_q;
	logic [LEN_W-1:0]  found_length_q;

	imm_ctl_t          ctl;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [CW-1:0]     count;
	logic [ENT_W-1:0]  wr_data;
	logic [ENT_W-1:0]  rd_data;
	logic [ID_W-1:0]   rd_id;
	logic [LEN_W-1:0]  rd_len;
	logic [PAY_W-1:0]  rd_pay;
	logic              id_match;

	assign accept = start && !ctl.busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_payload_q <= '0;
			found_length_q  <= '0;
		end else if (ctl.hit) begin
			found_payload_q <= rd_pay;
			found_length_q  <= rd_len;
		end
	end

	// entry layout: identifier, length code, data bytes
	assign rd_id  = rd_data[ENT_W-1 -: ID_W];
	assign rd_len = rd_data[PAY_W +: LEN_W];
	assign rd_pay = rd_data[PAY_W-1:0];

	// the shared identifier comparator used by the search
	assign id_match = (rd_id == req_q.msg_id);

	// new entry on add, otherwise the neighbor read last cycle while closing a gap
	assign wr_data = ctl.wr_new ? {req_q.msg_id, req_q.length_code, req_q.payload[PAY_W-1:0]}
	                            : rd_data;

	imm_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (req_q.operation),
		.id_match (id_match),
		.ctl      (ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.count    (count)
	);

	imm_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENTRIES)
	) u_store (
		.clk     (clk),
		.wr_en   (ctl.wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign busy = ctl.busy;
	assign done = ctl.done;

	// fill count is final by the done cycle and holds through it
	assign result = '{
		status:        ctl.status,
		found_payload: DATA_W'(found_payload_q),
		found_length:  found_length_q,
		fill_level:    FILL_W'(count)
	};

endmodule

@@ design/imm_ram.sv @@
`timescale 1ns / 1ps

module imm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ design/imm_ctrl.sv @@
`timescale 1ns / 1ps
`include "id_match_message_fifo_unit_macros.svh"

module imm_ctrl #(
	parameter int ENTRIES = imm_pkg::ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  imm_pkg::imm_op_t             op,
	input  logic                         id_match,
	output imm_pkg::imm_ctl_t            ctl,
	output logic [$clog2(ENTRIES)-1:0]   rd_addr,
	output logic [$clog2(ENTRIES)-1:0]   wr_addr,
	output logic [$clog2(ENTRIES+1)-1:0] count
);

	import imm_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int SW = CW + 1;

	typedef enum logic [1:0] {
		IDLE,
		DISPATCH,
		SEARCH,
		SHIFT
	} state_t;

	state_t        state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	imm_status_t   status_q;
	logic          done_q;

	logic          full;
	logic          empty;
	logic [AW-1:0] head_inc;
	logic [CW-1:0] rd_logical;
	logic          wr_en;
	logic          wr_new;

	// ring position of an entry counted from the oldest
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(ENTRIES)) begin
			sum = sum - SW'(ENTRIES);
		end
		return AW'(sum);
	endfunction

	assign full     = (count_q == CW'(ENTRIES));
	assign empty    = (count_q == '0);
	assign head_inc = (head_q == AW'(ENTRIES - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		rd_logical = '0;
		wr_en      = 1'b0;
		wr_new     = 1'b0;
		wr_addr    = phys(head_q, idx_q);
		case (state_q)
			DISPATCH: begin
				if (op == OP_ADD) begin
					wr_en   = 1'b1;
					wr_new  = 1'b1;
					wr_addr = full ? head_q : phys(head_q, count_q);
				end
			end
			SEARCH: begin
				rd_logical = idx_q + 1'b1;
			end
			SHIFT: begin
				rd_logical = idx_q + CW'(2);
				wr_en      = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign rd_addr = phys(head_q, rd_logical);
	assign count   = count_q;

	assign ctl = '{
		busy:   (state_q != IDLE),
		done:   done_q,
		status: status_q,
		hit:    (state_q == SEARCH) && id_match,
		wr_en:  wr_en,
		wr_new: wr_new
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			head_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			status_q <= ST_OK;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= DISPATCH;
					end
				end
				DISPATCH: begin
					state_q  <= IDLE;
					done_q   <= 1'b1;
					status_q <= ST_OK;
					idx_q    <= '0;
					case (op)
						OP_ADD: begin
							if (full) begin
								head_q   <= head_inc;
								status_q <= ST_DROPPED;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
						OP_TAKE: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								state_q <= SEARCH;
								done_q  <= 1'b0;
							end
						end
						OP_DROP: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								head_q  <= head_inc;
								count_q <= count_q - 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				SEARCH: begin
					if (idx_q == count_q - 1'b1) begin
						state_q  <= IDLE;
						done_q   <= 1'b1;
						status_q <= id_match ? ST_OK : ST_NOT_FOUND;
						if (id_match) begin
							count_q <= count_q - 1'b1;
						end
					end else if (id_match) begin
						state_q <= SHIFT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				SHIFT: begin
					if (idx_q + CW'(2) == count_q) begin
						state_q  <= IDLE;
						done_q   <= 1'b1;
						status_q <= ST_OK;
						count_q  <= count_q - 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`IMM_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(ENTRIES), "fill count above depth")
	`IMM_ASSERT(a_head_range, clk, arst_n, head_q < AW'(ENTRIES - 1) || head_q == AW'(ENTRIES - 1), "head out of range")
	`IMM_ASSERT_IMPL(a_search_in_fill, clk, arst_n, state_q == SEARCH || state_q == SHIFT, idx_q < count_q)
	`IMM_ASSERT_IMPL(a_done_idle, clk, arst_n, done_q, state_q == IDLE)

endmodule

@@ test/id_match_message_fifo_unit_checker.sv @@
`timescale 1ns / 1ps

module id_match_message_fifo_unit_checker #(
	parameter int ENTRIES       = imm_pkg::ENTRIES_DEF,
	parameter int PAYLOAD_BYTES = imm_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  imm_pkg::imm_req_t request,
	input  logic              done,
	input  imm_pkg::imm_rsp_t result,
	output int                mismatches,
	output int                pending
);

	import imm_pkg::*;

	localparam logic [DATA_W-1:0] DATA_KEEP = (PAYLOAD_BYTES >= 8) ? {DATA_W{1'b1}} :
		((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);

	// shadow of the message store, oldest entry at index 0
	logic [ID_W-1:0]   held_id   [ENTRIES];
	logic [DATA_W-1:0] held_data [ENTRIES];
	logic [LEN_W-1:0]  held_len  [ENTRIES];
	int                held_count = 0;

	imm_rsp_t awaited_results[$];
	imm_rsp_t want;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	task automatic flag_mismatch(input string what, input logic [63:0] exp_val,
		input logic [63:0] got_val);
		$display("%0t mismatch: %s expected %0h got %0h", $time, what, exp_val, got_val);
		mismatches++;
	endtask

	// remove one entry and close the gap toward the head
	function automatic void remove_entry(input int pos);
		for (int i = pos; i + 1 < held_count; i++) begin
			held_id[i]   = held_id[i + 1];
			held_data[i] = held_data[i + 1];
			held_len[i]  = held_len[i + 1];
		end
		held_count--;
	endfunction

	function automatic imm_rsp_t apply_store_op(input imm_req_t req);
		imm_rsp_t rsp;
		int hit_at;
		rsp = '0;
		rsp.status = ST_OK;
		hit_at = -1;
		case (req.operation)
			OP_ADD: begin
				// full store: oldest goes, new one still lands at the tail
				if (held_count >= ENTRIES) begin
					remove_entry(0);
					rsp.status = ST_DROPPED;
				end
				held_id[held_count]   = req.msg_id;
				held_data[held_count] = req.payload & DATA_KEEP;
				held_len[held_count]  = req.length_code;
				held_count++;
			end
			OP_TAKE: begin
				if (held_count == 0) begin
					rsp.status = ST_EMPTY;
				end else begin
					for (int i = held_count - 1; i >= 0; i--) begin
						if (held_id[i] == req.msg_id) hit_at = i;
					end
					if (hit_at >= 0) begin
						rsp.found_payload = held_data[hit_at];
						rsp.found_length  = held_len[hit_at];
						remove_entry(hit_at);
					end else begin
						rsp.status = ST_NOT_FOUND;
					end
				end
			end
			OP_DROP: begin
				if (held_count == 0) rsp.status = ST_EMPTY;
				else remove_entry(0);
			end
			default: ;
		endcase
		rsp.fill_level = FILL_W'(held_count);
		return rsp;
	endfunction

	// result first: a new request may be taken on the same edge as done
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch("result with none awaited, fill", 0, result.fill_level);
				end else begin
					want = awaited_results.pop_front();
					if (result.status !== want.status)
						flag_mismatch("status", want.status, result.status);
					if (result.found_payload !== want.found_payload)
						flag_mismatch("found_payload", want.found_payload, result.found_payload);
					if (result.found_length !== want.found_length)
						flag_mismatch("found_length", want.found_length, result.found_length);
					if (result.fill_level !== want.fill_level)
						flag_mismatch("fill_level", want.fill_level, result.fill_level);
				end
			end
			if (start && !busy) awaited_results.push_back(apply_store_op(request));
			pending <= awaited_results.size();
		end
	end

endmodule

@@ test/id_match_message_fifo_unit_tb.sv @@
`timescale 1ns / 1ps

module id_match_message_fifo_unit_tb;
	import imm_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 3;
	// random requests that the block acts on; spare opcodes come on top
	localparam int RANDOM_ITEMS = 1625;
	// final stretch of the random part sent back to back
	localparam int CALM_TAIL    = 200;
	// a take scans and shifts one entry per cycle, so even a full store
	// answers far inside this many quiet cycles
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int POOL_SIZE    = 8;

	// opcode with no operation behind it
	localparam logic [1:0]      OP_SPARE = 2'd3;
	localparam logic [ID_W-1:0] ID_MAX   = {ID_W{1'b1}};

	logic     clk     = 1'b0;
	logic     arst_n  = 1'b0;
	logic     start   = 1'b0;
	imm_req_t request = '0;
	logic     busy;
	logic     done;
	imm_rsp_t result;

	int mismatches;
	int pending;
	int stall_cycles = 0;

	// small set of identifiers reused by adds and takes so that takes
	// mostly hit and the store often holds several entries with one id
	logic [ID_W-1:0] id_pool [POOL_SIZE];

	always #CLK_HALF clk = ~clk;

	id_match_message_fifo_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	id_match_message_fifo_unit_checker store_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending)
	);

	function automatic logic [DATA_W-1:0] random_data();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [ID_W-1:0] random_id();
		return ID_W'($urandom);
	endfunction

	function automatic logic [ID_W-1:0] pool_id();
		return id_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	function automatic imm_req_t make_request(input logic [1:0] op, input logic [ID_W-1:0] id,
		input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] data);
		imm_req_t req;
		req.operation   = imm_op_t'(op);
		req.msg_id      = id;
		req.length_code = len;
		req.payload     = data;
		return req;
	endfunction

	// present one request and hold it until the block takes it; an optional
	// short gap with start low (and junk on the request bus) comes first
	task automatic send_request(input imm_req_t req, input bit with_gaps);
		int gap;
		gap = (with_gaps && $urandom_range(0, 99) < 30) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			start   <= 1'b0;
			request <= make_request(2'($urandom_range(0, 3)), random_id(),
				4'($urandom_range(0, 15)), random_data());
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// watchdog: cycles with neither a request taken nor a result shown
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("** id_match_message_fifo_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		imm_req_t        req;
		logic [ID_W-1:0] dup_id;
		logic [ID_W-1:0] id;
		int              counted;
		int              sent;
		int              add_share;
		int              roll;
		bit              calm;

		foreach (id_pool[i]) id_pool[i] = random_id();
		id_pool[0] = '0;
		id_pool[1] = ID_MAX;
		dup_id = random_id();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: take, drop and the spare opcode
		send_request(make_request(OP_TAKE, '0, '0, '0), 1'b1);
		send_request(make_request(OP_DROP, ID_MAX, '1, '1), 1'b1);
		send_request(make_request(OP_SPARE, random_id(), '1, random_data()), 1'b1);

		// fill past capacity: first entry carries all-ones fields, second all
		// zeros, every third shares one id; the last add pushes out the oldest
		for (int i = 0; i <= 16; i++) begin
			if (i == 0) req = make_request(OP_ADD, ID_MAX, '1, '1);
			else if (i == 1) req = make_request(OP_ADD, '0, '0, '0);
			else if (i % 3 == 0) req = make_request(OP_ADD, dup_id, 4'(i), random_data());
			else req = make_request(OP_ADD, random_id(), 4'(i), random_data());
			send_request(req, 1'b1);
		end

		// several matches: oldest one goes
		send_request(make_request(OP_TAKE, dup_id, '0, '0), 1'b1);
		// the all-ones id was pushed out, so this one misses
		send_request(make_request(OP_TAKE, ID_MAX, '1, '1), 1'b1);
		send_request(make_request(OP_TAKE, '0, '1, '1), 1'b1);
		send_request(make_request(OP_DROP, random_id(), '0, '0), 1'b1);
		send_request(make_request(OP_SPARE, random_id(), '0, random_data()), 1'b1);

		// random part: the add share swings between fill-up, balanced and
		// drain-down phases so the store sweeps from empty to overflow
		counted = 0;
		sent = 0;
		add_share = 50;
		while (counted < RANDOM_ITEMS) begin
			if (sent % 60 == 0) begin
				case ($urandom_range(0, 2))
					0: add_share = 75;
					1: add_share = 50;
					default: add_share = 25;
				endcase
			end
			calm = (counted >= RANDOM_ITEMS - CALM_TAIL);
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				req = make_request(OP_SPARE, random_id(), 4'($urandom_range(0, 15)),
					random_data());
			end else if ($urandom_range(0, 99) < add_share) begin
				id = ($urandom_range(0, 99) < 80) ? pool_id() : random_id();
				// now and then swap a fresh id into the pool
				if ($urandom_range(0, 99) < 15) id_pool[$urandom_range(0, POOL_SIZE - 1)] = id;
				req = make_request(OP_ADD, id, 4'($urandom_range(0, 15)), random_data());
			end else if ($urandom_range(0, 99) < 65) begin
				id = ($urandom_range(0, 99) < 80) ? pool_id() : random_id();
				req = make_request(OP_TAKE, id, 4'($urandom_range(0, 15)), random_data());
			end else begin
				req = make_request(OP_DROP, random_id(), 4'($urandom_range(0, 15)),
					random_data());
			end
			send_request(req, !calm);
			if (req.operation != OP_SPARE) counted++;
			sent++;
		end
		start <= 1'b0;

		// let the last result arrive, then watch for strays
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0) begin
			$display("** id_match_message_fifo_unit: PASSED **");
		end else begin
			$display("** id_match_message_fifo_unit: FAILED **");
		end
		$finish;
	end

endmodule
